### src/buddy_block_allocator_macros.svh
// Assertion macros for the buddy block allocator checker.
// Used by bba_checker.sv; relies on clk and rst_n being in scope.
`ifndef BUDDY_BLOCK_ALLOCATOR_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled during reset
`define BBA_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Fixed-delay implication, disabled during reset
`define BBA_ASSERT_DELAY2(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
        else $error(msg);

`endif

### src/bba_pkg.sv
// Shared types and codes for the buddy block allocator.
// No dependencies; imported by every allocator module and the checker.
package bba_pkg;

    // Fixed field widths of the request and result transfers
    localparam int SIZE_W   = 32;
    localparam int OFFSET_W = 20;
    localparam int STATUS_W = 2;
    // Enough to hold any level 0..32
    localparam int LEVEL_W  = 6;

    // Operation codes
    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 2'd3;

    typedef struct packed {
        logic              operation;
        logic [SIZE_W-1:0] request_size;
    } bba_req_t;

    typedef struct packed {
        logic                granted;
        logic [OFFSET_W-1:0] block_offset;
        logic [STATUS_W-1:0] status;
    } bba_rsp_t;

    // Command kinds passed from the front end to the back end
    typedef enum logic [1:0] {
        CMD_ALLOC,
        CMD_RELEASE,
        CMD_REJECT
    } bba_kind_t;

    typedef struct packed {
        bba_kind_t           kind;
        logic [LEVEL_W-1:0]  level;
        logic [STATUS_W-1:0] status;
    } bba_cmd_t;

endpackage

### src/bba_front.sv
// Front end: classifies a request and computes its buddy level.
// Depends on bba_pkg.
module bba_front
    import bba_pkg::*;
#(
    parameter int POOL_LOG2 = 20,
    parameter int MIN_LOG2  = 3
)
(
    input  bba_req_t request,
    output bba_cmd_t cmd
);

    localparam logic [LEVEL_W-1:0] MIN_LVL  = LEVEL_W'(MIN_LOG2);
    localparam logic [LEVEL_W-1:0] POOL_LVL = LEVEL_W'(POOL_LOG2);

    logic [SIZE_W-1:0]  size_m1;
    logic [LEVEL_W-1:0] bit_len;
    logic [LEVEL_W-1:0] level;

    // Round the size up to a power of two: level is the bit length of size-1
    always_comb
    begin
        size_m1 = request.request_size - SIZE_W'(1);
        bit_len = '0;
        for (int i = 0; i < SIZE_W; i++)
        begin
            if (size_m1[i])
            begin
                bit_len = LEVEL_W'(i + 1);
            end
        end
        level = (bit_len < MIN_LVL) ? MIN_LVL : bit_len;
    end

    // Classify the request into a command for the back end
    always_comb
    begin
        cmd.kind   = CMD_ALLOC;
        cmd.level  = level;
        cmd.status = ST_OK;
        if (request.operation == OP_RELEASE)
        begin
            cmd.kind = CMD_RELEASE;
        end
        else if (request.request_size == '0)
        begin
            cmd.kind   = CMD_REJECT;
            cmd.status = ST_ZERO;
        end
        else if (level > POOL_LVL)
        begin
            cmd.kind   = CMD_REJECT;
            cmd.status = ST_TOO_LARGE;
        end
    end

endmodule

### src/bba_queue.sv
// Two-entry command queue between the front end and the back end.
// Depends on bba_pkg.
module bba_queue
    import bba_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  bba_cmd_t push_cmd,
    input  logic     pop,
    output bba_cmd_t head,
    output logic     empty,
    output logic     full
);

    localparam int DEPTH = 2;

    bba_cmd_t                   entry_reg [DEPTH];
    logic                       wr_ptr_reg, wr_ptr_next;
    logic                       rd_ptr_reg, rd_ptr_next;
    logic [$clog2(DEPTH+1)-1:0] count_reg, count_next;
    logic                       do_push;
    logic                       do_pop;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == ($clog2(DEPTH+1))'(DEPTH));
    assign head  = entry_reg[rd_ptr_reg];

    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold queued commands
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### src/bba_back.sv
// Back end: per-level free flags and offsets, split search and result register.
// Depends on bba_pkg.
module bba_back
    import bba_pkg::*;
#(
    parameter int POOL_LOG2 = 20
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    input  bba_cmd_t cmd,
    output logic     done,
    output bba_rsp_t result
);

    localparam int OFS_W = POOL_LOG2;
    // Whole pool free as one block at the top level
    localparam logic [POOL_LOG2:0] TOP_ONLY = {1'b1, {POOL_LOG2{1'b0}}};

    logic [POOL_LOG2:0] free_reg, free_next;
    // Top-level offset is always zero, so only the lower levels are stored
    logic [OFS_W-1:0]   ofs_reg [POOL_LOG2];
    logic               done_reg, done_next;
    bba_rsp_t           rsp_reg, rsp_next;

    logic [POOL_LOG2:0] ge_lvl;
    logic [POOL_LOG2:0] avail;
    logic [POOL_LOG2:0] hit_oh;
    logic [POOL_LOG2:0] below_hit;
    logic [POOL_LOG2:0] split;
    logic               found;
    logic [OFS_W-1:0]   base;
    logic               do_alloc;
    logic [OFS_W+OFFSET_W-1:0] base_ext;

    // Find the smallest free level at or above the requested level
    always_comb
    begin
        ge_lvl    = '0;
        avail     = '0;
        hit_oh    = '0;
        below_hit = '0;
        found     = 1'b0;
        for (int j = 0; j <= POOL_LOG2; j++)
        begin
            ge_lvl[j] = (LEVEL_W'(j) >= cmd.level);
            avail[j]  = free_reg[j] && ge_lvl[j];
        end
        for (int j = 0; j <= POOL_LOG2; j++)
        begin
            if (avail[j] && !found)
            begin
                found     = 1'b1;
                hit_oh[j] = 1'b1;
            end
            else if (!found)
            begin
                below_hit[j] = 1'b1;
            end
        end
        split = (ge_lvl & below_hit) & {(POOL_LOG2+1){found}};
    end

    // Select the base offset of the hit level
    always_comb
    begin
        base = '0;
        for (int j = 0; j < POOL_LOG2; j++)
        begin
            base = base | (ofs_reg[j] & {OFS_W{hit_oh[j]}});
        end
    end

    assign base_ext = {{OFFSET_W{1'b0}}, base};
    assign do_alloc = cmd_valid && (cmd.kind == CMD_ALLOC) && found;

    // Execute the command and build the result
    always_comb
    begin
        free_next             = free_reg;
        done_next             = cmd_valid;
        rsp_next.granted      = 1'b0;
        rsp_next.block_offset = '0;
        rsp_next.status       = ST_OK;
        if (cmd_valid)
        begin
            case (cmd.kind)
                CMD_RELEASE:
                begin
                    free_next = TOP_ONLY;
                end
                CMD_ALLOC:
                begin
                    if (found)
                    begin
                        free_next             = (free_reg & ~hit_oh) | split;
                        rsp_next.granted      = 1'b1;
                        rsp_next.block_offset = base_ext[OFFSET_W-1:0];
                    end
                    else
                    begin
                        rsp_next.status = ST_NO_SPACE;
                    end
                end
                default:
                begin
                    rsp_next.status = cmd.status;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg <= TOP_ONLY;
            done_reg <= 1'b0;
        end
        else
        begin
            free_reg <= free_next;
            done_reg <= done_next;
        end
    end

    // Register the result and record the free upper buddies at every split level
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        for (int j = 0; j < POOL_LOG2; j++)
        begin
            if (do_alloc && split[j])
            begin
                ofs_reg[j] <= base | (OFS_W'(1) << j);
            end
        end
    end

    assign done   = done_reg;
    assign result = rsp_reg;

endmodule

### src/buddy_block_allocator.sv
// Top level of the allocation-only buddy allocator.
// Depends on bba_pkg, bba_front, bba_queue and bba_back.
//
//   Channel   Handshake              Payload
//   request   start, busy            request (bba_req_t)
//   result    done (one-cycle pulse) result  (bba_rsp_t)
//
// A request is taken when start is high and busy is low; its result pulses done
// after the command queue and result register. One request per cycle is
// sustained: level search and split writes all resolve in the same cycle.
// Reset leaves the whole pool free at the top level. The receiver cannot
// stall, so busy rises only if the command queue fills.
module buddy_block_allocator
    import bba_pkg::*;
#(
    parameter int POOL_LOG2 = 20,
    parameter int MIN_LOG2  = 3
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  bba_req_t request,
    output logic     done,
    output bba_rsp_t result
);

    bba_cmd_t front_cmd;
    bba_cmd_t head_cmd;
    logic     q_empty;
    logic     q_full;

    // Classify the incoming request
    bba_front #(
        .POOL_LOG2 (POOL_LOG2),
        .MIN_LOG2  (MIN_LOG2)
    ) u_front (
        .request (request),
        .cmd     (front_cmd)
    );

    // Buffer commands between the two halves
    bba_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (start),
        .push_cmd (front_cmd),
        .pop      (!q_empty),
        .head     (head_cmd),
        .empty    (q_empty),
        .full     (q_full)
    );

    // Carry out allocations and releases
    bba_back #(
        .POOL_LOG2 (POOL_LOG2)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!q_empty),
        .cmd       (head_cmd),
        .done      (done),
        .result    (result)
    );

    assign busy = q_full;

endmodule

### src/bba_checker.sv
// Port-level checker for the buddy block allocator, bound to the top level.
// Depends on bba_pkg and buddy_block_allocator_macros.svh.
`include "buddy_block_allocator_macros.svh"

module bba_checker
    import bba_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     start,
    input logic     busy,
    input bba_req_t request,
    input logic     done,
    input bba_rsp_t result
);

    // A result only follows an earlier accepted transfer
    `BBA_ASSERT_IMPLY(a_done_follows_accept, done, $past(start && !busy, 2), "orphan result")

    // A refused request reports a zero offset
    `BBA_ASSERT_IMPLY(a_no_grant_zero_ofs, done && !result.granted, result.block_offset == '0, "offset without grant")

    // A grant always reports success
    `BBA_ASSERT_IMPLY(a_grant_ok, done && result.granted, result.status == ST_OK, "grant with error status")

    // A release completes cleanly, with no grant and an OK status
    `BBA_ASSERT_DELAY2(a_release_result, start && !busy && request.operation == OP_RELEASE, done && !result.granted && result.status == ST_OK, "bad release result")

    // A zero-size allocate reports the zero-size error
    `BBA_ASSERT_DELAY2(a_zero_size, start && !busy && request.operation == OP_ALLOC && request.request_size == '0, done && result.status == ST_ZERO, "zero size not flagged")

endmodule

bind buddy_block_allocator bba_checker u_checker (.*);
